// ===== rtl/core/igfr_pkg.sv =====
// Package for the idle-gap frame receiver: field widths, command codes
// and the reset value of the idle tick register. No dependencies.
`default_nettype none

package igfr_pkg;

  localparam int CMD_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int TICKS_W = 8;
  localparam int LEN_W   = 6;

  localparam logic [TICKS_W-1:0] IDLE_TICKS_RESET = 8'd5;

  typedef enum logic [CMD_W-1:0] {
    CMD_BYTE  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_FLUSH = 2'd2
  } cmd_t;

endpackage : igfr_pkg

`default_nettype wire

// ===== rtl/core/igfr_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds while the read enable is low. No dependencies.
`default_nettype none

module igfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 63,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : igfr_ram

`default_nettype wire

// ===== rtl/core/idle_gap_frame_receiver_unit.sv =====
// Idle-gap frame receiver: gathers bytes in a frame store, closes the frame
// after a gap of idle ticks and drains it. Uses igfr_pkg and igfr_ram.
//
//   channel | signals                                    | direction
//   --------+--------------------------------------------+----------
//   cfg     | cfg_valid, cfg_ready, cfg_data             | in
//   in      | in_valid, in_stall, cmd, rx_byte           | in
//   out     | out_valid, out_stall, frame_byte,          | out
//           |   last_of_frame, empty_frame, frame_length |
//
// Byte, flush and non-closing tick items never start a drain, and input is
// never stalled outside a drain. A closing tick starts a drain that reads the
// frame store through its single read port, one byte per cycle while the
// output register is free, and holds the input until the last byte (or the
// empty-frame result) is loaded. Output stalls freeze the drain in place.
// Reset (rst, synchronous) empties the frame, clears the countdown and sets
// idle_ticks to 5; the store itself is not cleared.
`default_nettype none

module idle_gap_frame_receiver_unit
  import igfr_pkg::*;
#(
  parameter int BUFFER_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [TICKS_W-1:0] cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [CMD_W-1:0]   cmd,
  input  wire logic [BYTE_W-1:0]  rx_byte,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [BYTE_W-1:0]  frame_byte,
  output logic                    last_of_frame,
  output logic                    empty_frame,
  output logic      [LEN_W-1:0]   frame_length
);

  localparam int CAP    = BUFFER_DEPTH - 1;
  localparam int CNT_W  = $clog2(BUFFER_DEPTH);
  localparam int ADDR_W = (CAP > 1) ? $clog2(CAP) : 1;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAP);

  typedef enum logic {
    S_IDLE,
    S_DRAIN
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   fill_count;
  logic [TICKS_W-1:0] idle_countdown;
  logic [TICKS_W-1:0] idle_ticks;
  logic [CNT_W-1:0]   drain_len;
  logic [CNT_W-1:0]   rd_idx;
  logic               pend;
  logic               pend_last;

  logic               in_acc;
  logic               store_byte;
  logic               close_tick;
  logic               out_free;
  logic               issue;
  logic               out_load;
  logic [BYTE_W-1:0]  rdata;
  logic [LEN_W+CNT_W-1:0] len_ext;

  assign cfg_ready  = 1'b1;
  assign in_stall   = (state != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign store_byte = in_acc && (cmd == CMD_BYTE) && (fill_count < CAP_CNT);
  assign close_tick = in_acc && (cmd == CMD_TICK) &&
                      (idle_countdown == TICKS_W'(1));

  assign out_free = !out_valid || !out_stall;
  // Read the next byte when none is pending or the pending one can move to the output this cycle.
  assign issue    = (state == S_DRAIN) && (rd_idx < drain_len) && (!pend || out_free);
  assign out_load = (state == S_DRAIN) && out_free &&
                    (pend || (drain_len == '0));
  assign len_ext  = {{LEN_W{1'b0}}, drain_len};

  // Drain only starts after the closing item, so a read never meets a
  // write to the same entry in one cycle.
  igfr_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(CAP)
  ) u_store (
    .clk  (clk),
    .we   (store_byte),
    .waddr(fill_count[ADDR_W-1:0]),
    .wdata(rx_byte),
    .re   (issue),
    .raddr(rd_idx[ADDR_W-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      fill_count     <= '0;
      idle_countdown <= '0;
      idle_ticks     <= IDLE_TICKS_RESET;
      pend           <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        idle_ticks <= cfg_data;
      end

      if (in_acc) begin
        case (cmd_t'(cmd))
          CMD_BYTE: begin
            // Full store: drop the byte and empty the frame.
            fill_count     <= store_byte ? fill_count + CNT_W'(1) : '0;
            idle_countdown <= idle_ticks;
          end
          CMD_FLUSH: begin
            fill_count <= '0;
          end
          CMD_TICK: begin
            if (idle_countdown != '0) begin
              idle_countdown <= idle_countdown - TICKS_W'(1);
            end
            if (close_tick) begin
              drain_len  <= fill_count;
              fill_count <= '0;
              rd_idx     <= '0;
              pend       <= 1'b0;
              state      <= S_DRAIN;
            end
          end
          default: begin
          end
        endcase
      end

      if (state == S_DRAIN) begin
        if (issue) begin
          rd_idx    <= rd_idx + CNT_W'(1);
          pend_last <= (rd_idx == drain_len - CNT_W'(1));
          pend      <= 1'b1;
        end else if (out_load) begin
          pend <= 1'b0;
        end
      end

      if (out_load) begin
        out_valid    <= 1'b1;
        frame_length <= len_ext[LEN_W-1:0];
        if (drain_len == '0) begin
          frame_byte    <= '0;
          last_of_frame <= 1'b1;
          empty_frame   <= 1'b1;
          state         <= S_IDLE;
        end else begin
          frame_byte    <= rdata;
          last_of_frame <= pend_last;
          empty_frame   <= 1'b0;
          if (pend_last) begin
            state <= S_IDLE;
          end
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_close_starts_drain: assert property (@(posedge clk) disable iff (rst)
    close_tick |=> (state == S_DRAIN))
    else $error("closing tick did not start a drain");

  a_last_ends_drain: assert property (@(posedge clk) disable iff (rst)
    (out_load && pend && pend_last) |=> (state == S_IDLE) && last_of_frame)
    else $error("drain did not end after the last byte");

  a_pend_has_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN && pend) |-> (rd_idx != '0) && (rd_idx <= drain_len))
    else $error("pending read without an issued address");

  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CAP_CNT)
    else $error("fill count beyond store capacity");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && empty_frame) |-> last_of_frame && (frame_length == '0))
    else $error("empty frame result malformed");

endmodule : idle_gap_frame_receiver_unit

`default_nettype wire

// ===== tb/idle_gap_frame_receiver_unit_tb.sv =====
// Self-checking testbench for idle_gap_frame_receiver_unit: a directed table,
// then random frame traffic under several idle tick settings, with random gaps
// and stalls but in one steady phase. Uses igfr_pkg, the unit and igfr_ram.
`timescale 1ns / 100ps

module idle_gap_frame_receiver_unit_tb;
  import igfr_pkg::*;

  localparam int BUFFER_DEPTH  = 64;
  localparam int CAPACITY      = BUFFER_DEPTH - 1;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int NUM_DIRECTED  = 23;
  localparam int NUM_PHASES    = 6;

  // command value that the unit must ignore
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] fbyte;
    logic              last;
    logic              empty;
    logic [LEN_W-1:0]  len;
  } frame_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]  op;
    logic [BYTE_W-1:0] data;
    logic              typed;
    frame_result_t     want;
  } stim_row_t;

  // idle_ticks is 5 out of reset
  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{CMD_TICK,   8'h00, 1'b0, '0},  // tick with no frame pending
    '{CMD_BYTE,   8'h00, 1'b0, '0},
    '{CMD_BYTE,   8'hFF, 1'b0, '0},
    '{CMD_UNUSED, 8'hAA, 1'b0, '0},  // ignored between bytes
    '{CMD_TICK,   8'h00, 1'b0, '0},
    '{CMD_TICK,   8'h00, 1'b0, '0},
    '{CMD_TICK,   8'h00, 1'b0, '0},
    '{CMD_TICK,   8'h00, 1'b0, '0},
    '{CMD_TICK,   8'h00, 1'b0, '0},  // closes the two byte frame
    '{CMD_BYTE,   8'h5A, 1'b0, '0},
    '{CMD_FLUSH,  8'h00, 1'b0, '0},  // countdown keeps running
    '{CMD_TICK,   8'h00, 1'b0, '0},
    '{CMD_TICK,   8'h00, 1'b0, '0},
    '{CMD_TICK,   8'h00, 1'b0, '0},
    '{CMD_TICK,   8'h00, 1'b0, '0},
    '{CMD_TICK,   8'h00, 1'b1, '{8'h00, 1'b1, 1'b1, 6'd0}},
    '{CMD_BYTE,   8'hFF, 1'b0, '0},
    '{CMD_TICK,   8'h00, 1'b0, '0},
    '{CMD_TICK,   8'h00, 1'b0, '0},
    '{CMD_TICK,   8'h00, 1'b0, '0},
    '{CMD_TICK,   8'h00, 1'b0, '0},
    '{CMD_TICK,   8'h00, 1'b1, '{8'hFF, 1'b1, 1'b0, 6'd1}},
    '{CMD_FLUSH,  8'h55, 1'b0, '0}
  };

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [TICKS_W-1:0] cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic [CMD_W-1:0]   cmd;
  logic [BYTE_W-1:0]  rx_byte;
  logic               out_valid;
  logic               out_stall;
  logic [BYTE_W-1:0]  frame_byte;
  logic               last_of_frame;
  logic               empty_frame;
  logic [LEN_W-1:0]   frame_length;

  // predictor state
  logic [BYTE_W-1:0]  gathered [CAPACITY];
  int                 gathered_count;
  logic [TICKS_W-1:0] silence_left;
  logic [TICKS_W-1:0] idle_ticks_setting;

  frame_result_t      frame_q [$];
  int                 mismatch_count;
  int                 quiet_cycles;
  int                 stall_left;
  bit                 steady;

  idle_gap_frame_receiver_unit #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_byte   (frame_byte),
    .last_of_frame(last_of_frame),
    .empty_frame  (empty_frame),
    .frame_length (frame_length)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Advance the frame assembly by one item and collect the frame it closes.
  function automatic void assemble_frame(input logic [CMD_W-1:0] op,
                                         input logic [BYTE_W-1:0] data,
                                         ref frame_result_t closed[$]);
    int n;
    closed.delete();
    case (op)
      CMD_BYTE: begin
        if (gathered_count < CAPACITY) begin
          gathered[gathered_count] = data;
          gathered_count++;
        end else begin
          gathered_count = 0;  // store full: drop the byte, empty the frame
        end
        silence_left = idle_ticks_setting;
      end
      CMD_FLUSH: begin
        gathered_count = 0;
      end
      CMD_TICK: begin
        if (silence_left != 0) begin
          silence_left--;
          if (silence_left == 0) begin
            n = gathered_count;
            gathered_count = 0;
            if (n == 0) begin
              closed.push_back('{8'h00, 1'b1, 1'b1, '0});
            end else begin
              for (int k = 0; k < n; k++) begin
                closed.push_back('{gathered[k], k == n - 1, 1'b0, LEN_W'(n)});
              end
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int pick_gap();
    if (steady || $urandom_range(0, 99) < 55) return 0;
    return pick_len();
  endfunction

  task automatic note_mismatch(input string what, input frame_result_t want,
                               input frame_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t %s: expected byte/last/empty/len %h %b %b %0d, got %h %b %b %0d",
               $time, what, want.fbyte, want.last, want.empty, want.len,
               got.fbyte, got.last, got.empty, got.len);
    end
  endtask

  task automatic send_item(input logic [CMD_W-1:0] op, input logic [BYTE_W-1:0] data,
                           input logic typed, input frame_result_t want);
    int gap;
    frame_result_t closed [$];
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= op;
    rx_byte  <= data;
    do @(posedge clk); while (in_stall);
    assemble_frame(op, data, closed);
    if (typed) frame_q.push_back(want);
    else foreach (closed[k]) frame_q.push_back(closed[k]);
  endtask

  // Hold the sender until every expected result has come and the unit is idle.
  task automatic drain_frames();
    in_valid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_idle_ticks(input logic [TICKS_W-1:0] value);
    drain_frames();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    idle_ticks_setting = value;
  endtask

  task automatic run_traffic(input int frames, input int ph);
    int kind;
    int len;
    int ticks;
    for (int f = 0; f < frames; f++) begin
      if (f == frames / 2) drain_frames();
      kind = $urandom_range(0, 99);
      if (f == 1 && (ph == 0 || ph == 4)) kind = 0;
      if (kind < 70) begin
        // well-formed frame: bytes (with an odd tick or unused item), then at least idle_ticks_setting ticks
        len = $urandom_range(0, 8);
        if (f == 1 && ph == 0) len = CAPACITY;
        else if (f == 1 && ph == 4) len = CAPACITY + 1;
        for (int k = 0; k < len; k++) begin
          send_item(CMD_BYTE, BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
          if ($urandom_range(0, 9) == 0) begin
            send_item(($urandom_range(0, 1) != 0) ? CMD_TICK : CMD_UNUSED,
                      BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
          end
        end
        ticks = int'(idle_ticks_setting) + $urandom_range(0, 2);
        for (int k = 0; k < ticks; k++) send_item(CMD_TICK, 8'h00, 1'b0, '0);
      end else if (kind < 85) begin
        // noise of any command
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          send_item(CMD_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)),
                    1'b0, '0);
        end
      end else begin
        // broken frame: maybe flushed, then up to idle_ticks_setting ticks
        len = $urandom_range(0, 5);
        for (int k = 0; k < len; k++) begin
          send_item(CMD_BYTE, BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
        end
        if ($urandom_range(0, 1) != 0) send_item(CMD_FLUSH, 8'h00, 1'b0, '0);
        ticks = $urandom_range(0, int'(idle_ticks_setting));
        for (int k = 0; k < ticks; k++) send_item(CMD_TICK, 8'h00, 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 9) < 3) begin
      out_stall  <= 1'b1;
      stall_left <= pick_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    frame_result_t got;
    frame_result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{frame_byte, last_of_frame, empty_frame, frame_length};
      if (frame_q.size() == 0) begin
        note_mismatch("result with nothing pending", '0, got);
      end else begin
        want = frame_q.pop_front();
        if (got.fbyte !== want.fbyte || got.last !== want.last ||
            got.empty !== want.empty || got.len !== want.len) begin
          note_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  // End the run when no channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL idle_gap_frame_receiver_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [TICKS_W-1:0] setting;
    int frames;
    clk                = 1'b0;
    rst               <= 1'b1;
    cfg_valid         <= 1'b0;
    cfg_data          <= '0;
    in_valid          <= 1'b0;
    cmd               <= CMD_BYTE;
    rx_byte           <= '0;
    out_stall         <= 1'b0;
    stall_left         = 0;
    quiet_cycles       = 0;
    mismatch_count     = 0;
    steady             = 1'b0;
    gathered_count     = 0;
    silence_left       = '0;
    idle_ticks_setting = IDLE_TICKS_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NUM_DIRECTED; r++) begin
      send_item(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].data,
                DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       setting = 8'd1;
        1:       setting = 8'd255;
        2:       setting = 8'd0;  // bytes load a zero countdown
        3:       setting = TICKS_W'($urandom_range(2, 9));
        4:       setting = 8'd3;
        default: setting = TICKS_W'($urandom_range(1, 12));
      endcase
      frames = (ph == 1) ? 1 : 2;
      write_idle_ticks(setting);
      steady = (ph == 3);
      run_traffic(frames, ph);
    end

    drain_frames();
    if (mismatch_count == 0 && frame_q.size() == 0) begin
      $display("PASS idle_gap_frame_receiver_unit");
    end else begin
      $display("FAIL idle_gap_frame_receiver_unit");
    end
    $finish;
  end

endmodule
